### rtl/vcfs_pkg.sv
`default_nettype none

package vcfs_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int REG_W  = 13;
    localparam int DIM_W  = 15;
    localparam int IDX_W  = 3;
    localparam int CH_W   = 8;
    localparam int LANES  = 4;
    localparam int PIX_W  = CH_W * LANES;
    localparam int NUM_W  = CH_W + REG_W;
    localparam int QBITS  = CH_W;
    localparam int STEP_W = $clog2(QBITS);

    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH   = 3'd0,
        REG_TOP_H   = 3'd1,
        REG_BOT_H   = 3'd2,
        REG_OVERLAP = 3'd3,
        REG_MODE    = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef enum logic [2:0] {
        SRC_ZERO = 3'd0,
        SRC_TOP  = 3'd1,
        SRC_BOT  = 3'd2,
        SRC_AVG  = 3'd3,
        SRC_RAMP = 3'd4
    } t_src;

    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctl;

endpackage

`default_nettype wire

### rtl/vcfs_lane.sv
`default_nettype none

module vcfs_lane import vcfs_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_lane_ctl         i_ctl,
    input  wire logic [CH_W-1:0]   i_top,
    input  wire logic [CH_W-1:0]   i_bot,
    input  wire logic [REG_W-1:0]  i_k,
    input  wire logic [REG_W-1:0]  i_ov,
    output logic      [CH_W-1:0]   o_avg,
    output logic      [CH_W-1:0]   o_quo
);

    logic [REG_W-1:0] wt_top;
    logic [NUM_W-1:0] p_top;
    logic [NUM_W-1:0] p_bot;
    logic [NUM_W-1:0] n_rem;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_dvs;
    logic [QBITS-1:0] r_quo;
    logic             ge;
    logic [CH_W:0]    sum;

    assign wt_top = i_ov - i_k;
    assign p_top  = {{REG_W{1'b0}}, i_top} * {{CH_W{1'b0}}, wt_top};
    assign p_bot  = {{REG_W{1'b0}}, i_bot} * {{CH_W{1'b0}}, i_k};
    assign n_rem  = p_top + p_bot;

    // quotient is known to fit in eight bits, so the divisor starts at ov << 7
    assign ge = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= n_rem;
            r_dvs <= NUM_W'({i_ov, {(QBITS-1){1'b0}}});
        end else if (i_ctl.step) begin
            if (ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs <= r_dvs >> 1;
            r_quo <= {r_quo[QBITS-2:0], ge};
        end
    end

    assign sum   = {1'b0, i_top} + {1'b0, i_bot};
    assign o_avg = sum[CH_W:1];
    assign o_quo = r_quo;

endmodule

`default_nettype wire

### rtl/vcfs_merge.sv
`default_nettype none

module vcfs_merge import vcfs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire t_src              i_src,
    input  wire logic [PIX_W-1:0]  i_top,
    input  wire logic [PIX_W-1:0]  i_bot,
    input  wire logic [PIX_W-1:0]  i_avg,
    input  wire logic [PIX_W-1:0]  i_ramp,
    input  wire logic              i_row_end,
    input  wire logic              i_frame_end,
    input  wire logic              i_err,
    input  wire logic              i_out_stall,
    output logic                   o_space,
    output logic                   o_out_valid,
    output logic      [PIX_W-1:0]  o_out_pixel,
    output logic                   o_out_row_end,
    output logic                   o_out_frame_end,
    output logic                   o_out_config_error
);

    logic             r_valid;
    logic [PIX_W-1:0] r_pix;
    logic             r_rend;
    logic             r_fend;
    logic             r_err;
    logic [PIX_W-1:0] sel;

    always_comb begin
        case (i_src)
            SRC_TOP:  sel = i_top;
            SRC_BOT:  sel = i_bot;
            SRC_AVG:  sel = i_avg;
            SRC_RAMP: sel = i_ramp;
            default:  sel = '0;
        endcase
    end

    assign o_space = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pix  <= sel;
            r_rend <= i_row_end;
            r_fend <= i_frame_end;
            r_err  <= i_err;
        end
    end

    assign o_out_valid        = r_valid;
    assign o_out_pixel        = r_pix;
    assign o_out_row_end      = r_rend;
    assign o_out_frame_end    = r_fend;
    assign o_out_config_error = r_err;

endmodule

`default_nettype wire

### rtl/vertical_crossfade_stitcher_core.sv
// on copy, zero and average rows an accepted request goes from idle to done; on ramp
//   rows it passes a multiply step, 8 divide steps and an output load
// a new request is taken only in idle, after done has loaded the last result, and done
//   waits for output space; each channel lane has its own 8-step restoring divider
// reset: registers return to width 1, heights 1, overlap 0, mode 0; counters clear,
//   output register empties
`default_nettype none

module vertical_crossfade_stitcher_core import vcfs_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [REG_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [PIX_W-1:0]  i_top_pixel,
    input  wire logic [PIX_W-1:0]  i_bottom_pixel,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [PIX_W-1:0]  o_out_pixel,
    output logic                   o_row_end,
    output logic                   o_frame_end,
    output logic                   o_config_error
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = $clog2(2 * MAX_HEIGHT);
    localparam logic [DIM_W-1:0] LIM_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] LIM_H = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] ONE   = DIM_W'(1);

    logic [REG_W-1:0]  r_width, r_top_h, r_bot_h, r_overlap;
    logic              r_mode;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_bit, n_bit;

    logic [PIX_W-1:0]  r_tp, r_bp;
    logic [REG_W-1:0]  r_k;
    t_src              r_src;
    logic              r_rend, r_fend, r_err;

    logic [DIM_W-1:0]  w_ext, w_cl, w_eff, th_ext, th, bh_ext, bh, ov;
    logic [DIM_W-1:0]  sum_h, rows_raw, rows, blend_start, row_ext, col_ext;
    logic              err, rend, fend, accept, space, load;
    t_src              src;
    logic [REG_W-1:0]  k;
    t_lane_ctl         lane_ctl;
    logic [PIX_W-1:0]  avg_px, ramp_px;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= REG_W'(1);
            r_top_h   <= REG_W'(1);
            r_bot_h   <= REG_W'(1);
            r_overlap <= '0;
            r_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:   r_width   <= i_cfg_data;
                REG_TOP_H:   r_top_h   <= i_cfg_data;
                REG_BOT_H:   r_bot_h   <= i_cfg_data;
                REG_OVERLAP: r_overlap <= i_cfg_data;
                REG_MODE:    r_mode    <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    // frame geometry
    always_comb begin
        w_ext    = DIM_W'(r_width);
        w_cl     = (w_ext > LIM_W) ? LIM_W : w_ext;
        w_eff    = (w_cl == '0) ? ONE : w_cl;
        th_ext   = DIM_W'(r_top_h);
        th       = (th_ext > LIM_H) ? LIM_H : th_ext;
        bh_ext   = DIM_W'(r_bot_h);
        bh       = (bh_ext > LIM_H) ? LIM_H : bh_ext;
        ov       = DIM_W'(r_overlap);
        err      = (ov > th) || (ov > bh);
        sum_h    = th + bh;
        rows_raw = err ? sum_h : sum_h - ov;
        rows     = (rows_raw == '0) ? ONE : rows_raw;
        row_ext  = DIM_W'(r_row);
        col_ext  = DIM_W'(r_col);
        blend_start = th - ov;
        k        = REG_W'(row_ext - blend_start);

        if (err) begin
            src = SRC_ZERO;
        end else if (row_ext < blend_start) begin
            src = SRC_TOP;
        end else if (row_ext < th) begin
            src = r_mode ? SRC_AVG : SRC_RAMP;
        end else begin
            src = SRC_BOT;
        end

        rend  = (col_ext + ONE) >= w_eff;
        fend  = rend && ((row_ext + ONE) >= rows);
        n_col = rend ? '0 : r_col + COL_W'(1);
        n_row = fend ? '0 : (rend ? r_row + ROW_W'(1) : r_row);
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign load       = (r_state == S_DONE) && space;

    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (src == SRC_RAMP) ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                n_bit   = STEP_W'(QBITS - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_bit == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_bit = r_bit - STEP_W'(1);
                end
            end
            S_DONE: begin
                if (space) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tp   <= i_top_pixel;
            r_bp   <= i_bottom_pixel;
            r_k    <= k;
            r_src  <= src;
            r_rend <= rend;
            r_fend <= fend;
            r_err  <= err;
        end
    end

    assign lane_ctl.load = (r_state == S_MUL);
    assign lane_ctl.step = (r_state == S_DIV);

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        vcfs_lane u_lane (
            .i_clk (i_clk),
            .i_ctl (lane_ctl),
            .i_top (r_tp[g*CH_W +: CH_W]),
            .i_bot (r_bp[g*CH_W +: CH_W]),
            .i_k   (r_k),
            .i_ov  (r_overlap),
            .o_avg (avg_px[g*CH_W +: CH_W]),
            .o_quo (ramp_px[g*CH_W +: CH_W])
        );
    end

    vcfs_merge u_merge (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (load),
        .i_src              (r_src),
        .i_top              (r_tp),
        .i_bot              (r_bp),
        .i_avg              (avg_px),
        .i_ramp             (ramp_px),
        .i_row_end          (r_rend),
        .i_frame_end        (r_fend),
        .i_err              (r_err),
        .i_out_stall        (i_out_stall),
        .o_space            (space),
        .o_out_valid        (o_out_valid),
        .o_out_pixel        (o_out_pixel),
        .o_out_row_end      (o_row_end),
        .o_out_frame_end    (o_frame_end),
        .o_out_config_error (o_config_error)
    );

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("request accepted without leaving idle");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_bit == '0) |=> (r_state == S_DONE))
        else $error("divide did not finish after last step");

    a_frame_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_frame_end || o_row_end))
        else $error("frame end without row end");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_config_error) |-> (o_out_pixel == '0))
        else $error("config error with nonzero pixel");

endmodule

`default_nettype wire

### dv/stitch_checker.sv
`default_nettype none

module stitch_checker import vcfs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [REG_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic [PIX_W-1:0]  i_top_pixel,
    input  wire logic [PIX_W-1:0]  i_bottom_pixel,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic [PIX_W-1:0]  i_out_pixel,
    input  wire logic              i_row_end,
    input  wire logic              i_frame_end,
    input  wire logic              i_config_error,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic             frame_end;
        logic             cfg_err;
    } t_stitch_px;

    t_stitch_px expected_px_q[$];

    logic [REG_W-1:0] width_r;
    logic [REG_W-1:0] top_h_r;
    logic [REG_W-1:0] bot_h_r;
    logic [REG_W-1:0] overlap_r;
    logic             avg_mode_r;
    int unsigned      col_cnt;
    int unsigned      row_cnt;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        return (v > hi) ? hi : v;
    endfunction

    // works out the stitched pixel for the current raster position and advances it
    function automatic t_stitch_px stitch_next(input logic [PIX_W-1:0] tp,
                                               input logic [PIX_W-1:0] bp);
        int unsigned w;
        int unsigned th;
        int unsigned bh;
        int unsigned ov;
        int unsigned rows;
        int unsigned k;
        int unsigned t_ch;
        int unsigned b_ch;
        int unsigned v;
        int          c;
        t_stitch_px  r;
        w  = clamp_dim(32'(width_r), DEF_MAX_WIDTH);
        th = clamp_dim(32'(top_h_r), DEF_MAX_HEIGHT);
        bh = clamp_dim(32'(bot_h_r), DEF_MAX_HEIGHT);
        ov = 32'(overlap_r);
        if (w == 0) w = 1;
        r.cfg_err = (ov > th) || (ov > bh);
        rows = r.cfg_err ? th + bh : th + bh - ov;
        if (rows == 0) rows = 1;

        r.pixel = '0;
        if (!r.cfg_err) begin
            if (row_cnt < th - ov) begin
                r.pixel = tp;
            end else if (row_cnt < th) begin
                k = row_cnt - (th - ov);
                for (c = 0; c < LANES; c++) begin
                    t_ch = 32'(tp[c*CH_W +: CH_W]);
                    b_ch = 32'(bp[c*CH_W +: CH_W]);
                    if (avg_mode_r) begin
                        v = (t_ch + b_ch) >> 1;
                    end else begin
                        v = (t_ch * (ov - k) + b_ch * k) / ov;
                    end
                    r.pixel[c*CH_W +: CH_W] = v[CH_W-1:0];
                end
            end else begin
                // past the top region, including rows left over after a resize
                r.pixel = bp;
            end
        end

        r.row_end   = (col_cnt + 1) >= w;
        r.frame_end = r.row_end && ((row_cnt + 1) >= rows);
        if (r.row_end) begin
            col_cnt = 0;
            row_cnt = r.frame_end ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_stitch_px got;
        t_stitch_px want;
        if (!i_rst_n) begin
            width_r    = REG_W'(1);
            top_h_r    = REG_W'(1);
            bot_h_r    = REG_W'(1);
            overlap_r  = '0;
            avg_mode_r = 1'b0;
            col_cnt    = 0;
            row_cnt    = 0;
            expected_px_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_WIDTH:   width_r    = i_cfg_data;
                    REG_TOP_H:   top_h_r    = i_cfg_data;
                    REG_BOT_H:   bot_h_r    = i_cfg_data;
                    REG_OVERLAP: overlap_r  = i_cfg_data;
                    REG_MODE:    avg_mode_r = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall)
                expected_px_q.push_back(stitch_next(i_top_pixel, i_bottom_pixel));

            if (i_out_valid && !i_out_stall) begin
                got = '{pixel: i_out_pixel, row_end: i_row_end,
                        frame_end: i_frame_end, cfg_err: i_config_error};
                if (expected_px_q.size() == 0) begin
                    $error("unexpected result: out_pixel %08h with no request pending",
                           got.pixel);
                    o_fail_count++;
                end else begin
                    want = expected_px_q.pop_front();
                    if (got.pixel !== want.pixel) begin
                        $error("out_pixel: expected %08h, got %08h", want.pixel, got.pixel);
                        o_fail_count++;
                    end
                    if (got.row_end !== want.row_end) begin
                        $error("row_end: expected %0b, got %0b", want.row_end, got.row_end);
                        o_fail_count++;
                    end
                    if (got.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, got %0b",
                               want.frame_end, got.frame_end);
                        o_fail_count++;
                    end
                    if (got.cfg_err !== want.cfg_err) begin
                        $error("config_error: expected %0b, got %0b",
                               want.cfg_err, got.cfg_err);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_px_q.size();
    end

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top import vcfs_pkg::*; ();

    localparam int RANDOM_ITEMS   = 1400;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 12;
    localparam int DRAIN_CYCLES   = 30;
    localparam int WATCHDOG_LIMIT = 4000;

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             cfg_we         = 1'b0;
    t_reg_idx         cfg_index      = REG_WIDTH;
    logic [REG_W-1:0] cfg_data       = '0;
    logic             in_valid       = 1'b0;
    logic             in_stall;
    logic [PIX_W-1:0] top_pixel      = '0;
    logic [PIX_W-1:0] bottom_pixel   = '0;
    logic             out_valid;
    logic             out_stall      = 1'b0;
    logic [PIX_W-1:0] out_pixel;
    logic             row_end;
    logic             frame_end;
    logic             config_error;

    int fail_count;
    int pending;
    int items_sent    = 0;
    int stuck_cycles  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    bit tx_gaps       = 1'b1;
    logic rx_gaps     = 1'b1;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    vertical_crossfade_stitcher_core u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_top_pixel    (top_pixel),
        .i_bottom_pixel (bottom_pixel),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_pixel    (out_pixel),
        .o_row_end      (row_end),
        .o_frame_end    (frame_end),
        .o_config_error (config_error)
    );

    stitch_checker u_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_top_pixel    (top_pixel),
        .i_bottom_pixel (bottom_pixel),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_pixel    (out_pixel),
        .i_row_end      (row_end),
        .i_frame_end    (frame_end),
        .i_config_error (config_error),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // receiver: random stalls, plus a long hold-off whenever one is requested
    always @(posedge clk) begin
        if (hold_left == 0 && hold_served != hold_requests) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= rx_gaps && ($urandom_range(99) < 23);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic logic [PIX_W-1:0] rand_px();
        logic [PIX_W-1:0] p;
        int               c;
        p = $urandom;
        // channel extremes now and then
        if ($urandom_range(9) == 0) begin
            for (c = 0; c < LANES; c++)
                p[c*CH_W +: CH_W] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    // valid stays high from one request to the next unless a gap is drawn
    task automatic offer_pair(input logic [PIX_W-1:0] t, input logic [PIX_W-1:0] b);
        if (tx_gaps) begin
            while ($urandom_range(99) < 23) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        top_pixel    <= t;
        bottom_pixel <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic offer_random(input int n);
        repeat (n) offer_pair(rand_px(), rand_px());
    endtask

    task automatic go_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setup(input logic [REG_W-1:0] w, input logic [REG_W-1:0] th,
                               input logic [REG_W-1:0] bh, input logic [REG_W-1:0] ov,
                               input logic avg);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_TOP_H;
        cfg_data  <= th;
        @(posedge clk);
        cfg_index <= REG_BOT_H;
        cfg_data  <= bh;
        @(posedge clk);
        cfg_index <= REG_OVERLAP;
        cfg_data  <= ov;
        @(posedge clk);
        cfg_index <= REG_MODE;
        cfg_data  <= {{(REG_W-1){1'b0}}, avg};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [REG_W-1:0] w;
        logic [REG_W-1:0] th;
        logic [REG_W-1:0] bh;
        logic [REG_W-1:0] ov;
        logic             avg;
        int unsigned      lo;
        int               sel;
        int               n;
        int               phase;
        int               target;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: one top copy row, one bottom copy row
        offer_pair(32'hFFFF_FFFF, 32'h0000_0000);
        offer_pair(32'h0000_0000, 32'hFFFF_FFFF);
        go_quiet();

        // whole frame is overlap, linear ramp
        apply_setup(2, 2, 2, 2, 1'b0);
        offer_pair(32'hFFFF_FFFF, 32'h0000_0000);
        offer_pair(32'h1234_5678, 32'h8765_4321);
        offer_pair(32'hFFFF_FFFF, 32'h0000_0000);
        offer_pair(32'h01FF_80FE, 32'hFF01_80FF);
        go_quiet();

        // same geometry, plain average, channel sum overflow
        apply_setup(2, 2, 2, 2, 1'b1);
        offer_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_pair(32'hFFFF_FFFF, 32'h0000_0000);
        offer_pair(32'h0000_0000, 32'h0000_0000);
        offer_pair(32'hA5A5_A5A5, 32'h5A5A_5A5A);
        go_quiet();

        // overlap taller than the top image
        apply_setup(2, 2, 2, 3, 1'b0);
        offer_random(2);
        go_quiet();

        // zero width and zero rows
        apply_setup(0, 0, 0, 0, 1'b0);
        offer_random(2);
        go_quiet();

        // oversized registers clamp; all rows are ramp rows
        apply_setup(8191, 8191, 8191, 4096, 1'b0);
        offer_pair(32'hFFFF_FFFF, 32'h0000_0000);
        offer_random(2);
        go_quiet();
        // shrink the width mid-row: the column count is past the row length
        apply_setup(1, 8191, 8191, 4096, 1'b0);
        offer_random(3);
        go_quiet();

        // oversized overlap on maximum heights
        apply_setup(4096, 4096, 4096, 8191, 1'b1);
        offer_random(2);
        go_quiet();

        target = items_sent + RANDOM_ITEMS;
        phase  = 0;
        while (items_sent < target) begin
            sel = $urandom_range(99);
            avg = 1'($urandom_range(1));
            if (sel < 6) begin
                w  = REG_W'($urandom_range(1, 8191));
                th = REG_W'($urandom_range(0, 8191));
                bh = REG_W'($urandom_range(0, 8191));
                lo = (th < bh) ? 32'(th) : 32'(bh);
                ov = $urandom_range(1) ? th : REG_W'($urandom_range(0, lo));
                n  = $urandom_range(5, 30);
            end else begin
                w  = REG_W'($urandom_range(0, 8));
                th = REG_W'($urandom_range(0, 6));
                bh = REG_W'($urandom_range(0, 6));
                lo = (th < bh) ? 32'(th) : 32'(bh);
                ov = (sel < 18) ? REG_W'(lo + $urandom_range(1, 3))
                                : REG_W'($urandom_range(0, lo));
                n  = $urandom_range(6, 64);
            end

            tx_gaps = !(phase >= 15 && phase < 23);
            rx_gaps <= !(phase >= 15 && phase < 23);

            apply_setup(w, th, bh, ov, avg);
            if (phase == 5) begin
                // receiver holds off while requests keep coming at full rate
                hold_requests <= hold_requests + 1;
                tx_gaps = 1'b0;
                offer_random(80);
                tx_gaps = 1'b1;
            end else begin
                offer_random(n);
            end
            go_quiet();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
